// ----- rtl/core/cascaded_stereo_slew_limiter_unit_defines.svh -----
// Assertion macros used by the slew limiter controller.
// Expects clk and rst in scope at the point of use.
`ifndef CASCADED_STEREO_SLEW_LIMITER_UNIT_DEFINES_SVH
`define CASCADED_STEREO_SLEW_LIMITER_UNIT_DEFINES_SVH

// Concurrent check on the rising clock, off while reset is high.
`define CSLU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define CSLU_NEVER(lbl, cond, msg) \
  `CSLU_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/core/cslu_pkg.sv -----
// Package for the cascaded stereo slew limiter: sizes, constants, item types,
// register codes, controller states and saturation helpers. No dependencies.
package cslu_pkg;

  localparam int NUM_STAGES  = 10;
  localparam int SAMPLE_BITS = 24;
  localparam int STAGE_W     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int IDX_W       = $clog2(2 * NUM_STAGES);
  localparam int CFG_DATA_W  = 25;

  localparam logic signed [31:0] PHI_Q30    = 32'sd1737350766;
  localparam logic signed [31:0] INVPHI_Q30 = 32'sd663608942;
  localparam logic [15:0]        K078_Q16   = 16'd51118;

  typedef enum logic [1:0] {
    REG_BASE_THRESHOLD = 2'd0,
    REG_SKIP_STAGES    = 2'd1,
    REG_HALO           = 2'd2,
    REG_MIX            = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [24:0] base_threshold;
    logic [3:0]  skip_stages;
    logic [16:0] halo;
    logic [16:0] halo78;
    logic [16:0] mix;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_BUILD_START,
    ST_BUILD,
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_TEST1,
    ST_TEST2,
    ST_MIX,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic               load_in;
    logic               build_start;
    logic               build_step;
    logic [STAGE_W-1:0] build_idx;
    logic               load_stage;
    logic               mul;
    logic               test1;
    logic               test2;
    logic [STAGE_W-1:0] stage;
    logic               ch;
    logic               mix;
    logic               out_load;
  } ctrl_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [63:0] v
  );
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [SAMPLE_BITS-1:0] r;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) r = hi[SAMPLE_BITS-1:0];
    else if (v < lo) r = lo[SAMPLE_BITS-1:0];
    else r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/cascaded_stereo_slew_limiter_unit.sv -----
// Cascaded stereo slew limiter: one stereo frame per item, one result per item.
// Each active stage and channel runs through the load, multiply, test1 and test2 states,
// then mix and output follow; the one shared stage datapath takes a new item only after
// the last result is loaded into the output register, which a stalled result holds off.
// Synchronous reset clears state and control, then rebuilds the thresholds;
// a base_threshold write repeats that rebuild.
module cascaded_stereo_slew_limiter_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cslu_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cslu_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [24:0]          cfg_data
);
  import cslu_pkg::*;

  cfg_regs_t  cfg;
  ctrl_cmd_t  cmd;
  logic       cfg_we;
  logic       rebuild;
  logic [32:0] h78_prod;

  assign cfg_we   = cfg_valid & cfg_ready;
  assign rebuild  = cfg_we & (cfg_reg_t'(cfg_index) == REG_BASE_THRESHOLD);
  assign h78_prod = 33'(cfg_data[16:0]) * 33'(K078_Q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_threshold <= 25'd8388608;
      cfg.skip_stages    <= 4'd0;
      cfg.halo           <= 17'd0;
      cfg.halo78         <= 17'd0;
      cfg.mix            <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_THRESHOLD: cfg.base_threshold <= cfg_data;
        REG_SKIP_STAGES:    cfg.skip_stages    <= cfg_data[3:0];
        REG_HALO: begin
          cfg.halo   <= cfg_data[16:0];
          cfg.halo78 <= 17'((h78_prod + 33'd32768) >> 16);
        end
        REG_MIX:            cfg.mix            <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  cslu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_ready   (cfg_ready),
    .cfg_we      (cfg_we),
    .rebuild     (rebuild),
    .skip_stages (cfg.skip_stages),
    .cmd         (cmd)
  );

  cslu_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ----- rtl/core/cslu_ctrl.sv -----
// Controller for the slew limiter: threshold rebuild, stage/channel sequencing
// and output handshake. Uses cslu_pkg and the assertion macro header.
`include "cascaded_stereo_slew_limiter_unit_defines.svh"

module cslu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               cfg_ready,
  input  logic               cfg_we,
  input  logic               rebuild,
  input  logic [3:0]         skip_stages,
  output cslu_pkg::ctrl_cmd_t cmd
);
  import cslu_pkg::*;

  ctrl_state_t        state, state_next;
  logic [STAGE_W-1:0] stage, stage_next;
  logic               ch, ch_next;
  logic [STAGE_W-1:0] bidx, bidx_next;
  logic               skip_all;

  assign skip_all  = (int'(skip_stages) >= NUM_STAGES);
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BUILD_START;
      stage     <= '0;
      ch        <= 1'b0;
      bidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stage     <= stage_next;
      ch        <= ch_next;
      bidx      <= bidx_next;
      out_valid <= cmd.out_load | (out_valid & out_stall);
    end
  end

  always_comb begin
    state_next = state;
    stage_next = stage;
    ch_next    = ch;
    bidx_next  = bidx;
    in_stall   = 1'b1;
    cmd             = '0;
    cmd.stage       = stage;
    cmd.ch          = ch;
    cmd.build_idx   = bidx;
    unique case (state)
      ST_BUILD_START: begin
        cmd.build_start = 1'b1;
        if (NUM_STAGES > 1) begin
          bidx_next  = STAGE_W'(NUM_STAGES - 2);
          state_next = ST_BUILD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BUILD: begin
        // walk toward the first stage, one golden-ratio product per cycle
        cmd.build_step = 1'b1;
        if (bidx == '0) state_next = ST_IDLE;
        else bidx_next = bidx - 1'b1;
      end
      ST_IDLE: begin
        // hold the input while a register write lands
        if (cfg_we) begin
          if (rebuild) state_next = ST_BUILD_START;
        end else begin
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            ch_next     = 1'b0;
            stage_next  = STAGE_W'(skip_stages);
            state_next  = skip_all ? ST_MIX : ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_stage = 1'b1;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_TEST1;
      end
      ST_TEST1: begin
        cmd.test1  = 1'b1;
        state_next = ST_TEST2;
      end
      ST_TEST2: begin
        cmd.test2 = 1'b1;
        if (int'(stage) == NUM_STAGES - 1) begin
          if (!ch) begin
            ch_next    = 1'b1;
            stage_next = STAGE_W'(skip_stages);
            state_next = ST_LOAD;
          end else begin
            state_next = ST_MIX;
          end
        end else begin
          stage_next = stage + 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CSLU_ASSERT(a_stage_range, (state == ST_LOAD) |-> (int'(stage) < NUM_STAGES), "stage out of range")
  `CSLU_ASSERT(a_out_loaded, (state == ST_OUT && !(out_valid && out_stall)) |=> out_valid, "result lost")
  `CSLU_NEVER(a_build_range, (state == ST_BUILD) && (int'(bidx) > NUM_STAGES - 2), "build index off")

endmodule

// ----- rtl/core/cslu_dp.sv -----
// Datapath for the slew limiter: stage state, thresholds, per-stage arithmetic
// and the dry/wet mix. Driven by cslu_ctrl commands; uses cslu_pkg.
module cslu_dp (
  input  logic                clk,
  input  logic                rst,
  input  cslu_pkg::ctrl_cmd_t cmd,
  input  cslu_pkg::cfg_regs_t cfg,
  input  cslu_pkg::in_item_t  in_item,
  output cslu_pkg::out_item_t out_item
);
  import cslu_pkg::*;

  logic signed [31:0] prev [2*NUM_STAGES];
  logic signed [31:0] dec  [2*NUM_STAGES];
  logic signed [31:0] thr  [NUM_STAGES];
  logic signed [31:0] cur_t;

  logic signed [SAMPLE_BITS-1:0] x [2];
  logic signed [31:0] y [2];
  logic signed [52:0] acc [2];

  logic signed [31:0] p_r, q_r, t_r;
  logic signed [34:0] g_r;
  logic signed [35:0] a1_r, a2_r;
  logic signed [33:0] b1_r, b2_r;
  logic signed [31:0] qn_r;

  logic [IDX_W-1:0]   idx;
  logic signed [63:0] prod_t;
  logic signed [31:0] next_t;
  logic signed [32:0] diff;
  logic signed [17:0] h_s, omh, h78_s, omh78;
  logic signed [64:0] prod_g;
  logic signed [51:0] prod_a1, prod_a2;
  logic signed [49:0] prod_b1, prod_b2, prod_q;
  logic signed [31:0] y_cur;
  logic signed [35:0] d1, d2;
  logic signed [31:0] y_t1, y_t2;
  logic signed [18:0] wet, dry, dry_raw;

  assign idx = IDX_W'({cmd.stage, cmd.ch});

  assign prod_t = 64'(cur_t) * 64'(PHI_Q30);
  assign next_t = sat32((prod_t + 64'sd536870912) >>> 30);

  assign diff    = 33'(p_r) - 33'(q_r);
  assign h_s     = $signed({1'b0, cfg.halo});
  assign h78_s   = $signed({1'b0, cfg.halo78});
  assign omh     = 18'sd65536 - h_s;
  assign omh78   = 18'sd65536 - h78_s;
  assign prod_g  = 65'(diff) * 65'(INVPHI_Q30);
  assign prod_a1 = 52'(diff) * 52'(h_s);
  assign prod_a2 = 52'(diff) * 52'(h78_s);
  assign prod_b1 = 50'(t_r) * 50'(omh);
  assign prod_b2 = 50'(t_r) * 50'(omh78);
  assign prod_q  = 50'(p_r) * 50'(omh);

  assign y_cur = y[cmd.ch];
  assign d1    = 36'(y_cur) - 36'(p_r) - 36'(g_r);
  assign y_t1  = (d1 > 36'(t_r))
               ? sat32(64'(38'(p_r) - 38'(a1_r) + 38'(b1_r))) : y_cur;
  assign d2    = 36'(y_cur) - 36'(p_r) - 36'(g_r);
  assign y_t2  = (-37'(d2) > 37'(t_r))
               ? sat32(64'(38'(p_r) - 38'(a2_r) - 38'(b2_r))) : y_cur;

  assign wet     = $signed({1'b0, cfg.mix, 1'b0}) - 19'sd65536;
  assign dry_raw = 19'sd131072 - $signed({1'b0, cfg.mix, 1'b0});
  assign dry     = (dry_raw > 19'sd65536) ? 19'sd65536 : dry_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2 * NUM_STAGES; i++) begin
        prev[i] <= '0;
        dec[i]  <= '0;
      end
    end else if (cmd.test2) begin
      prev[idx] <= y_t2;
      dec[idx]  <= qn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      thr[NUM_STAGES-1] <= 32'(cfg.base_threshold);
      cur_t             <= 32'(cfg.base_threshold);
    end else if (cmd.build_step) begin
      thr[cmd.build_idx] <= next_t;
      cur_t              <= next_t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x[0] <= in_item.left_sample;
      x[1] <= in_item.right_sample;
      y[0] <= 32'(in_item.left_sample);
      y[1] <= 32'(in_item.right_sample);
    end else if (cmd.test1) begin
      y[cmd.ch] <= y_t1;
    end else if (cmd.test2) begin
      y[cmd.ch] <= y_t2;
    end
    if (cmd.load_stage) begin
      p_r <= prev[idx];
      q_r <= dec[idx];
      t_r <= thr[cmd.stage];
    end
    if (cmd.mul) begin
      g_r  <= 35'((prod_g + 65'sd536870912) >>> 30);
      a1_r <= 36'((prod_a1 + 52'sd32768) >>> 16);
      a2_r <= 36'((prod_a2 + 52'sd32768) >>> 16);
      b1_r <= 34'((prod_b1 + 50'sd32768) >>> 16);
      b2_r <= 34'((prod_b2 + 50'sd32768) >>> 16);
      qn_r <= sat32(64'((prod_q + 50'sd32768) >>> 16));
    end
    if (cmd.mix) begin
      for (int c = 0; c < 2; c++) begin
        acc[c] <= 53'(y[c]) * 53'(wet) + 53'(x[c]) * 53'(dry);
      end
    end
    if (cmd.out_load) begin
      out_item.left_out  <= sat_sample(64'((acc[0] + 53'sd32768) >>> 16));
      out_item.right_out <= sat_sample(64'((acc[1] + 53'sd32768) >>> 16));
    end
  end

endmodule
